/* rtl/rlbpg_pkg.sv */
package rlbpg_pkg;

    localparam int W_LEVEL  = 10;
    localparam int W_MODE   = 3;
    localparam int W_PHASE  = 19;
    localparam int W_PERIOD = 15;
    localparam int W_HALF   = 14;
    localparam int W_ACC    = W_LEVEL + W_HALF;

    localparam logic REQ_TICK     = 1'b0;
    localparam logic REQ_SET_MODE = 1'b1;

    localparam logic [W_MODE-1:0] MODE_WAIT_ACK    = 3'd0;
    localparam logic [W_MODE-1:0] MODE_ACK_RCVD    = 3'd1;
    localparam logic [W_MODE-1:0] MODE_READ_RCVD   = 3'd2;
    localparam logic [W_MODE-1:0] MODE_CUSTOM      = 3'd3;
    localparam logic [W_MODE-1:0] MODE_TERM_PEND   = 3'd4;
    localparam logic [W_MODE-1:0] MODE_TERMINATED  = 3'd5;

    localparam logic [W_PHASE-1:0]  TOGGLE_CYCLE_MS = 19'd300000;
    localparam logic [W_PHASE-1:0]  TOGGLE_ON_MS    = 19'd60000;
    localparam logic [W_LEVEL-1:0]  LEVEL_MAX       = 10'd1023;
    localparam logic [W_LEVEL-1:0]  LEVEL_DIM       = 10'd1020;
    localparam logic [W_PERIOD-1:0] PERIOD_RESET    = 15'd1000;
    localparam logic [W_PERIOD-1:0] PERIOD_WAIT_ACK = 15'd8000;
    localparam logic [W_PERIOD-1:0] PERIOD_ACK_RCVD = 15'd20000;
    localparam logic [W_PERIOD-1:0] PERIOD_READ     = 15'd400;
    localparam logic [W_PERIOD-1:0] PERIOD_CUSTOM   = 15'd1000;
    localparam logic [W_PERIOD-1:0] PERIOD_TERM     = 15'd200;

    typedef struct packed {
        logic               req_type;
        logic [W_MODE-1:0]  mode;
        logic [W_LEVEL-1:0] red_peak;
        logic [W_LEVEL-1:0] green_peak;
        logic [W_LEVEL-1:0] blue_peak;
    } t_in_word;

    typedef struct packed {
        logic [W_LEVEL-1:0] pwm_red;
        logic [W_LEVEL-1:0] pwm_green;
        logic [W_LEVEL-1:0] pwm_blue;
    } t_out_word;

    typedef struct packed {
        logic [W_LEVEL-1:0] peak;
        logic [W_HALF-1:0]  u;
        logic [W_HALF-1:0]  half;
        logic               falling;
    } t_md_req;

endpackage

/* rtl/rlbpg_muldiv.sv */
module rlbpg_muldiv
    import rlbpg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_md_req            i_req,
    output logic               o_done,
    output logic [W_LEVEL-1:0] o_level
);

    localparam int W_CNT = $clog2(2 * W_LEVEL);
    localparam logic [W_CNT-1:0] CNT_MUL_LAST = W_CNT'(W_LEVEL - 1);
    localparam logic [W_CNT-1:0] CNT_LAST     = W_CNT'(2 * W_LEVEL - 1);

    logic               r_busy;
    logic               r_done;
    logic               r_div;
    logic [W_CNT-1:0]   r_cnt;
    t_md_req            r_req;
    logic [W_LEVEL-1:0] r_pk;
    logic [W_ACC-1:0]   r_acc;
    logic [W_HALF-1:0]  r_rem;
    logic [W_LEVEL-1:0] r_q;

    logic [W_ACC-1:0]   n_acc;
    logic [W_HALF:0]    n_tmp;
    logic [W_HALF:0]    n_sub;
    logic               n_ge;

    always_comb begin
        n_acc = {r_acc[W_ACC-2:0], 1'b0} + (r_pk[W_LEVEL-1] ? W_ACC'(r_req.u) : '0);
        n_tmp = {r_rem, r_acc[W_LEVEL-1]};
        n_ge  = n_tmp >= {1'b0, r_req.half};
        n_sub = n_tmp - {1'b0, r_req.half};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_div  <= 1'b0;
                r_cnt  <= '0;
                r_req  <= i_req;
                r_pk   <= i_req.peak;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (!r_div) begin
                    r_pk  <= {r_pk[W_LEVEL-2:0], 1'b0};
                    r_acc <= n_acc;
                    if (r_cnt == CNT_MUL_LAST) begin
                        r_div <= 1'b1;
                        r_rem <= n_acc[W_ACC-1:W_LEVEL];
                    end
                end else begin
                    r_acc <= {r_acc[W_ACC-2:0], 1'b0};
                    r_rem <= n_ge ? n_sub[W_HALF-1:0] : n_tmp[W_HALF-1:0];
                    r_q   <= {r_q[W_LEVEL-2:0], n_ge};
                    if (r_cnt == CNT_LAST) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_level = r_req.falling ? (r_req.peak - r_q) : r_q;

endmodule

/* rtl/rgb_led_breathing_pattern_generator.sv */
// Channel   Direction  Signals
// in        input      i_in_valid, o_in_ready, i_in_word (t_in_word)
// out       output     o_out_valid, i_out_ready, o_out_word (t_out_word)
//
// A set-mode word gives no result; the input stays ready.
// A toggle-mode tick is registered in r_res on acceptance, then moved to the
// output register in ST_EMIT. A breathing-mode tick runs the shared serial
// multiply and divide unit on each color in turn: red, green, then blue.
// Reset is synchronous and active low; it loads the power-up mode state.
// A stalled output holds its word; the next input word is taken meanwhile.
module rgb_led_breathing_pattern_generator
    import rlbpg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          r_ch;
    logic                r_start;
    logic [W_PHASE-1:0]  r_phase;
    logic [W_PERIOD-1:0] r_period;
    logic [W_LEVEL-1:0]  r_peak_red;
    logic [W_LEVEL-1:0]  r_peak_green;
    logic [W_LEVEL-1:0]  r_peak_blue;
    logic                r_toggle;
    logic [W_HALF-1:0]   r_u;
    logic                r_falling;
    t_out_word           r_res;
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic                n_accept;
    logic [W_HALF-1:0]   n_half;
    logic                n_rise;
    logic [W_PHASE-1:0]  n_diff;
    logic [W_PHASE-1:0]  n_inc;
    t_md_req             n_req;
    logic                md_done;
    logic [W_LEVEL-1:0]  md_level;

    always_comb begin
        n_accept = i_in_valid && o_in_ready;
        n_half   = r_period[W_PERIOD-1:1];
        n_rise   = r_phase <= W_PHASE'(n_half);
        n_diff   = r_phase - W_PHASE'(n_half);
        n_inc    = r_phase + 1'b1;
        case (r_ch)
            CH_RED:   n_req.peak = r_peak_red;
            CH_GREEN: n_req.peak = r_peak_green;
            default:  n_req.peak = r_peak_blue;
        endcase
        n_req.u       = r_u;
        n_req.half    = n_half;
        n_req.falling = r_falling;
    end

    rlbpg_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_req   (n_req),
        .o_done  (md_done),
        .o_level (md_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ch         <= CH_RED;
            r_start      <= 1'b0;
            r_phase      <= '0;
            r_period     <= PERIOD_RESET;
            r_peak_red   <= '0;
            r_peak_green <= '0;
            r_peak_blue  <= '0;
            r_toggle     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && i_out_ready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (n_accept && i_in_word.req_type == REQ_SET_MODE) begin
                        r_phase  <= '0;
                        r_toggle <= 1'b0;
                        case (i_in_word.mode)
                            MODE_WAIT_ACK: begin
                                r_peak_red   <= '0;
                                r_peak_green <= LEVEL_MAX;
                                r_peak_blue  <= '0;
                                r_period     <= PERIOD_WAIT_ACK;
                            end
                            MODE_ACK_RCVD: begin
                                r_peak_red   <= '0;
                                r_peak_green <= LEVEL_MAX;
                                r_peak_blue  <= '0;
                                r_period     <= PERIOD_ACK_RCVD;
                            end
                            MODE_READ_RCVD: begin
                                r_peak_red   <= '0;
                                r_peak_green <= '0;
                                r_peak_blue  <= LEVEL_DIM;
                                r_period     <= PERIOD_READ;
                            end
                            MODE_CUSTOM: begin
                                r_peak_red   <= i_in_word.red_peak;
                                r_peak_green <= i_in_word.green_peak;
                                r_peak_blue  <= i_in_word.blue_peak;
                                r_period     <= PERIOD_CUSTOM;
                            end
                            MODE_TERM_PEND: begin
                                r_peak_red   <= LEVEL_DIM;
                                r_peak_green <= '0;
                                r_peak_blue  <= '0;
                                r_toggle     <= 1'b1;
                            end
                            MODE_TERMINATED: begin
                                r_peak_red   <= LEVEL_DIM;
                                r_peak_green <= '0;
                                r_peak_blue  <= '0;
                                r_period     <= PERIOD_TERM;
                            end
                            default: begin
                            end
                        endcase
                    end else if (n_accept) begin
                        if (r_toggle) begin
                            r_res.pwm_red   <= (r_phase < TOGGLE_ON_MS) ? LEVEL_MAX : '0;
                            r_res.pwm_green <= '0;
                            r_res.pwm_blue  <= '0;
                            r_phase <= (n_inc == TOGGLE_CYCLE_MS) ? '0 : n_inc;
                            r_state <= ST_EMIT;
                        end else begin
                            r_u       <= n_rise ? r_phase[W_HALF-1:0] : n_diff[W_HALF-1:0];
                            r_falling <= !n_rise;
                            r_phase   <= (n_inc == W_PHASE'(r_period)) ? '0 : n_inc;
                            r_ch      <= CH_RED;
                            r_start   <= 1'b1;
                            r_state   <= ST_CALC;
                        end
                    end
                end
                ST_CALC: begin
                    if (md_done) begin
                        case (r_ch)
                            CH_RED: begin
                                r_res.pwm_red <= md_level;
                                r_ch          <= CH_GREEN;
                                r_start       <= 1'b1;
                            end
                            CH_GREEN: begin
                                r_res.pwm_green <= md_level;
                                r_ch            <= CH_BLUE;
                                r_start         <= 1'b1;
                            end
                            default: begin
                                r_res.pwm_blue <= md_level;
                                r_state        <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_word  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* rtl/rlbpg_chk.sv */
module rlbpg_chk
    import rlbpg_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_word.req_type == REQ_TICK |=> !o_in_ready)
        else $error("ready after a tick word");

    a_set_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_word.req_type == REQ_SET_MODE |=> o_in_ready)
        else $error("not ready after a set-mode word");

    a_set_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_word.req_type == REQ_SET_MODE && !o_out_valid |=> !o_out_valid)
        else $error("set-mode word produced a result");

endmodule

bind rgb_led_breathing_pattern_generator rlbpg_chk u_rlbpg_chk (.*);

/* bench/tb_rgb_led_breathing_pattern_generator.sv */
`timescale 1ns / 1ps

module tb_rgb_led_breathing_pattern_generator;
    import rlbpg_pkg::*;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    int snd_idle = 0;
    int rcv_idle = 0;
    int err_count = 0;

    logic [W_PHASE-1:0]  exp_phase;
    logic [W_PERIOD-1:0] exp_period;
    logic [W_LEVEL-1:0]  exp_peak_red;
    logic [W_LEVEL-1:0]  exp_peak_green;
    logic [W_LEVEL-1:0]  exp_peak_blue;
    logic                exp_toggle;

    t_out_word levels_due[$];

    rgb_led_breathing_pattern_generator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [W_LEVEL-1:0] ramp_level(input logic [W_LEVEL-1:0] peak,
                                                      input int unsigned t,
                                                      input int unsigned half);
        int unsigned p;
        logic [W_LEVEL-1:0] lvl;
        p = 32'(peak);
        if (half == 0) begin
            lvl = '0;
        end else if (t <= half) begin
            lvl = W_LEVEL'((p * t) / half);
        end else begin
            lvl = W_LEVEL'(p - (p * (t - half)) / half);
        end
        return lvl;
    endfunction

    task automatic predict_levels(input t_in_word w);
        t_out_word   lv;
        int unsigned per;
        int unsigned t;
        int unsigned half;
        if (w.req_type == REQ_SET_MODE) begin
            exp_toggle = 1'b0;
            exp_phase  = '0;
            case (w.mode)
                MODE_WAIT_ACK: begin
                    exp_peak_red   = '0;
                    exp_peak_green = LEVEL_MAX;
                    exp_peak_blue  = '0;
                    exp_period     = PERIOD_WAIT_ACK;
                end
                MODE_ACK_RCVD: begin
                    exp_peak_red   = '0;
                    exp_peak_green = LEVEL_MAX;
                    exp_peak_blue  = '0;
                    exp_period     = PERIOD_ACK_RCVD;
                end
                MODE_READ_RCVD: begin
                    exp_peak_red   = '0;
                    exp_peak_green = '0;
                    exp_peak_blue  = LEVEL_DIM;
                    exp_period     = PERIOD_READ;
                end
                MODE_CUSTOM: begin
                    exp_peak_red   = w.red_peak;
                    exp_peak_green = w.green_peak;
                    exp_peak_blue  = w.blue_peak;
                    exp_period     = PERIOD_CUSTOM;
                end
                MODE_TERM_PEND: begin
                    exp_peak_red   = LEVEL_DIM;
                    exp_peak_green = '0;
                    exp_peak_blue  = '0;
                    exp_toggle     = 1'b1;
                end
                MODE_TERMINATED: begin
                    exp_peak_red   = LEVEL_DIM;
                    exp_peak_green = '0;
                    exp_peak_blue  = '0;
                    exp_period     = PERIOD_TERM;
                end
                default: begin
                end
            endcase
        end else if (exp_toggle) begin
            t = 32'(exp_phase % TOGGLE_CYCLE_MS);
            lv.pwm_red   = (t < TOGGLE_ON_MS) ? LEVEL_MAX : '0;
            lv.pwm_green = '0;
            lv.pwm_blue  = '0;
            exp_phase = W_PHASE'((t + 1) % TOGGLE_CYCLE_MS);
            levels_due.push_back(lv);
        end else begin
            per = 32'(exp_period);
            if (per == 0) begin
                per = 1;
            end
            t    = exp_phase % per;
            half = per / 2;
            lv.pwm_red   = ramp_level(exp_peak_red, t, half);
            lv.pwm_green = ramp_level(exp_peak_green, t, half);
            lv.pwm_blue  = ramp_level(exp_peak_blue, t, half);
            exp_phase = W_PHASE'((t + 1) % per);
            levels_due.push_back(lv);
        end
    endtask

    function automatic t_in_word make_word(input logic req,
                                           input logic [W_MODE-1:0] m,
                                           input logic [W_LEVEL-1:0] r,
                                           input logic [W_LEVEL-1:0] g,
                                           input logic [W_LEVEL-1:0] b);
        t_in_word w;
        w.req_type   = req;
        w.mode       = m;
        w.red_peak   = r;
        w.green_peak = g;
        w.blue_peak  = b;
        return w;
    endfunction

    function automatic logic [W_LEVEL-1:0] pick_peak();
        logic [W_LEVEL-1:0] p;
        case ($urandom_range(3, 0))
            0: p = '0;
            1: p = LEVEL_MAX;
            default: p = W_LEVEL'($urandom_range(1023, 0));
        endcase
        return p;
    endfunction

    task automatic send_word(input t_in_word w);
        if ($urandom_range(99, 0) < snd_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < snd_idle);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_levels(w);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) begin
            send_word(make_word(REQ_TICK, W_MODE'($urandom_range(7, 0)),
                                W_LEVEL'($urandom_range(1023, 0)),
                                W_LEVEL'($urandom_range(1023, 0)),
                                W_LEVEL'($urandom_range(1023, 0))));
        end
    endtask

    task automatic send_mode(input logic [W_MODE-1:0] m,
                             input logic [W_LEVEL-1:0] r,
                             input logic [W_LEVEL-1:0] g,
                             input logic [W_LEVEL-1:0] b);
        send_word(make_word(REQ_SET_MODE, m, r, g, b));
    endtask

    task automatic test_power_up();
        send_ticks(3);
    endtask

    task automatic test_each_mode();
        send_mode(MODE_CUSTOM, LEVEL_MAX, '0, 10'h2AA);
        send_ticks(3);
        send_mode(MODE_CUSTOM, '0, LEVEL_MAX, 10'h155);
        send_ticks(2);
        send_mode(MODE_WAIT_ACK, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        send_ticks(2);
        send_mode(MODE_ACK_RCVD, '0, '0, '0);
        send_ticks(1);
        send_mode(MODE_READ_RCVD, LEVEL_MAX, '0, LEVEL_MAX);
        send_ticks(2);
        send_mode(MODE_TERM_PEND, 10'h155, 10'h2AA, 10'h155);
        send_ticks(2);
        send_mode(MODE_TERMINATED, '0, LEVEL_MAX, '0);
        send_ticks(2);
        send_mode(3'd6, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        send_ticks(1);
        send_mode(3'd7, '0, '0, '0);
        send_ticks(1);
    endtask

    task automatic test_breathing_random(input int n_items);
        int sent;
        int run;
        logic [W_MODE-1:0] m;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9, 0))
                0: m = MODE_WAIT_ACK;
                1: m = MODE_ACK_RCVD;
                2, 3: m = MODE_READ_RCVD;
                4, 5: m = MODE_CUSTOM;
                6, 7: m = MODE_TERMINATED;
                8: m = MODE_TERM_PEND;
                default: m = W_MODE'($urandom_range(7, 6));
            endcase
            send_mode(m, pick_peak(), pick_peak(), pick_peak());
            if ($urandom_range(3, 0) == 0) begin
                case (m)
                    MODE_READ_RCVD: run = $urandom_range(460, 1);
                    MODE_CUSTOM: run = $urandom_range(620, 1);
                    MODE_TERMINATED: run = $urandom_range(260, 1);
                    default: run = $urandom_range(40, 0);
                endcase
            end else begin
                run = $urandom_range(60, 0);
            end
            send_ticks(run);
            sent += run + 1;
        end
    endtask

    task automatic test_toggle_window();
        send_mode(MODE_TERMINATED, '0, '0, '0);
        send_mode(MODE_TERM_PEND, '0, '0, '0);
        send_ticks(30);
        send_mode(3'd7, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        send_ticks(20);
    endtask

    initial begin
        t_out_word want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (levels_due.size() == 0) begin
                    $error("output word with no expectation: %h", o_out_word);
                    err_count++;
                end else begin
                    want = levels_due.pop_front();
                    if (o_out_word.pwm_red !== want.pwm_red) begin
                        $error("pwm_red expected %0d actual %0d",
                               want.pwm_red, o_out_word.pwm_red);
                        err_count++;
                    end
                    if (o_out_word.pwm_green !== want.pwm_green) begin
                        $error("pwm_green expected %0d actual %0d",
                               want.pwm_green, o_out_word.pwm_green);
                        err_count++;
                    end
                    if (o_out_word.pwm_blue !== want.pwm_blue) begin
                        $error("pwm_blue expected %0d actual %0d",
                               want.pwm_blue, o_out_word.pwm_blue);
                        err_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99, 0) >= rcv_idle);
        end
    end

    initial begin
        exp_phase      = '0;
        exp_period     = PERIOD_RESET;
        exp_peak_red   = '0;
        exp_peak_green = '0;
        exp_peak_blue  = '0;
        exp_toggle     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle = 38;
        rcv_idle = 54;
        test_power_up();
        test_each_mode();
        test_breathing_random(560);

        snd_idle = 54;
        rcv_idle = 38;
        test_breathing_random(560);

        snd_idle = 0;
        rcv_idle = 0;
        test_breathing_random(560);
        test_toggle_window();

        i_in_valid <= 1'b0;
        while (levels_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (levels_due.size() != 0) begin
            $error("%0d expected words never arrived", levels_due.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
